// ===== rtl/amv_pkg.sv =====
`default_nettype none
package amv_pkg;

  localparam int IdBytesDefault = 64;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_EXPECT = 2'd1,
    OP_BYTE   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    E_NONE      = 4'd0,
    E_NULL      = 4'd1,
    E_MALFORMED = 4'd2,
    E_MISSING   = 4'd3,
    E_DUP       = 4'd4,
    E_UNKNOWN   = 4'd5,
    E_TYPE      = 4'd6,
    E_INVALID   = 4'd7,
    E_MISMATCH  = 4'd8,
    E_TRAILING  = 4'd9
  } err_t;

  typedef enum logic [9:0] {
    PH_BEGIN       = 10'b0000000001,
    PH_OPEN        = 10'b0000000010,
    PH_KEY         = 10'b0000000100,
    PH_AFTER_KEY   = 10'b0000001000,
    PH_AFTER_COLON = 10'b0000010000,
    PH_STRING      = 10'b0000100000,
    PH_LITERAL     = 10'b0001000000,
    PH_NUMBER      = 10'b0010000000,
    PH_AFTER_VALUE = 10'b0100000000,
    PH_DONE        = 10'b1000000000
  } phase_t;

  localparam logic [2:0] F_CRASH = 3'd0;
  localparam logic [2:0] F_DUP   = 3'd1;
  localparam logic [2:0] F_DUR   = 3'd2;
  localparam logic [2:0] F_TIME  = 3'd3;
  localparam logic [2:0] F_SYM   = 3'd4;
  localparam logic [2:0] F_NONE  = 3'd5;

  localparam logic [6:0] KeyMax   = 7'd39;
  localparam logic [6:0] ValueMax = 7'd64;
  localparam logic [62:0] Max63   = {63{1'b1}};
  localparam logic [62:0] MulLim  = Max63 / 63'd10;

  // Key name bytes, first character in the top byte
  localparam logic [63:0]  KeyIdText     = 64'h63726173685f6964;
  localparam logic [103:0] KeyTimeText   = 104'h7365727665725f7574635f6d73;
  localparam logic [159:0] KeyStatusText = 160'h73796d626f6c69636174696f6e5f737461747573;

  // Key name character at position, zero past the end
  function automatic logic [7:0] key_char(input logic [2:0] k, input logic [5:0] i);
    logic [159:0] s;
    logic [7:0] c;
    s = '0;
    unique case (k)
      3'd0:    s = {KeyIdText, 96'd0};
      3'd1:    s = {"duplicate", 88'd0};
      3'd2:    s = {"durable", 104'd0};
      3'd3:    s = {KeyTimeText, 56'd0};
      default: s = KeyStatusText;
    endcase
    c = 8'd0;
    if (i < 6'd20) c = s[159 - 8 * i -: 8];
    return c;
  endfunction

  function automatic logic [6:0] key_len(input logic [2:0] k);
    logic [6:0] l;
    unique case (k)
      3'd0:    l = 7'd8;
      3'd1:    l = 7'd9;
      3'd2:    l = 7'd7;
      3'd3:    l = 7'd13;
      default: l = 7'd20;
    endcase
    return l;
  endfunction

  function automatic logic [7:0] lit_char(input logic w, input logic [2:0] i);
    logic [39:0] s;
    s = w ? "false" : {"true", 8'd0};
    return (i < 3'd5) ? s[39 - 8 * i -: 8] : 8'd0;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ack_message_validator.sv =====
// A result is computed from the end beat in the stage 1 register and loaded into the output register.
// Accepts one beat per cycle of any opcode while the output register is free; an end beat
// directly behind another end beat waits while the first result loads the output.
// The expected id memory has one write and one registered read port.
// Reset (synchronous, active high) clears the parser and the id length; id
// memory contents stay undefined and are only read below the written length.
`default_nettype none
module ack_message_validator import amv_pkg::*; #(
  parameter int ID_BYTES = IdBytesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       error_code,
  output logic             already_reported,
  output logic             stored_durably,
  output logic [62:0]      server_time_ms
);
  localparam int AW = $clog2(ID_BYTES);
  localparam int LW = $clog2(ID_BYTES + 1);

  logic [7:0] id_mem [ID_BYTES];
  logic [7:0] rd_data;

  // Stage 1 registers: accepted beat
  logic       s1_valid;
  op_t        s1_op;
  logic [7:0] s1_byte;

  logic [LW-1:0] exp_len;
  logic exp_over, exp_closed;
  phase_t phase;
  err_t   err;
  logic [4:0] seen;
  logic [2:0] cur;
  logic [4:0] cand;
  logic [6:0] tlen;
  logic idm;
  logic [2:0] lprog;
  logic lword;
  logic [62:0] num;
  logic dupf, durf;

  logic acc;
  logic res_free;

  // Next state of stage 1
  logic [LW-1:0] exp_len_n;
  logic exp_closed_n;
  logic [6:0] tlen_n;
  phase_t ph_n;
  err_t   err_n;
  logic [4:0] seen_n, cand_n;
  logic [2:0] cur_n, lprog_n;
  logic idm_n, lword_n, exp_over_n, dupf_n, durf_n;
  logic [62:0] num_n;
  logic res_v;
  logic [3:0] res_code;

  // Hold every beat while an unaccepted result is held, and an end beat while the result register is about to be loaded
  assign res_free = !out_valid || out_ready;
  assign in_ready = res_free && !(res_v && opcode == OP_END);
  assign acc = in_valid && in_ready;

  // Id memory: write at accept, read at the text position of the next string byte
  logic [AW-1:0] rd_addr;
  logic          exp_wr;
  assign exp_wr = acc && opcode == OP_EXPECT && !exp_closed_n && data_byte != 8'd0 &&
                  exp_len_n < LW'(ID_BYTES);

  always_ff @(posedge clk) begin
    if (exp_wr) id_mem[exp_len_n[AW-1:0]] <= data_byte;
    rd_data <= id_mem[rd_addr];
  end
  assign rd_addr = (32'(tlen_n) < ID_BYTES) ? AW'(tlen_n) : AW'(ID_BYTES - 1);

  // Stage 1 state update, in flight values fed forward for the next beat
  always_comb begin
    logic [7:0] b;
    logic [3:0] d;
    logic [4:0] bit1;
    logic fin;
    logic [65:0] prod;
    ph_n = phase; err_n = err; seen_n = seen; cand_n = cand; cur_n = cur;
    lprog_n = lprog; idm_n = idm; lword_n = lword; exp_over_n = exp_over;
    dupf_n = dupf; durf_n = durf; num_n = num; tlen_n = tlen;
    exp_len_n = exp_len; exp_closed_n = exp_closed;
    res_v = 1'b0; res_code = E_NONE;
    b = s1_byte; d = b[3:0]; fin = 1'b0; prod = '0;
    bit1 = 5'd1 << cur;
    if (s1_valid) begin
      unique case (s1_op)
        OP_START: begin
          ph_n = PH_BEGIN; err_n = E_NONE; seen_n = '0; cur_n = '0; cand_n = 5'h1f;
          tlen_n = '0; idm_n = 1'b1; lprog_n = '0; lword_n = 1'b0; num_n = '0;
          dupf_n = 1'b0; durf_n = 1'b0; exp_len_n = '0; exp_over_n = 1'b0;
          exp_closed_n = 1'b0;
        end
        OP_EXPECT: begin
          if (!exp_closed) begin
            if (b == 8'd0) exp_closed_n = 1'b1;
            else if (exp_len < LW'(ID_BYTES)) exp_len_n = exp_len + 1'b1;
            else exp_over_n = 1'b1;
          end
        end
        OP_BYTE: begin
          if (err == E_NONE) begin
            unique case (phase)
              PH_BEGIN: if (!is_ws(b)) begin
                if (b == "{") ph_n = PH_OPEN; else err_n = E_MALFORMED;
              end
              PH_OPEN: if (!is_ws(b)) begin
                if (b == "}") ph_n = PH_DONE;
                else if (b == "\"") begin
                  tlen_n = '0; cand_n = 5'h1f; ph_n = PH_KEY;
                end else err_n = E_TYPE;
              end
              PH_KEY: begin
                if (b == "\"") begin
                  cur_n = F_NONE;
                  for (int i = 0; i < 5; i++)
                    if (cand[i] && key_len(3'(i)) == tlen) cur_n = 3'(i);
                  ph_n = PH_AFTER_KEY;
                end else if (b == "\\" || b < 8'h20 || tlen >= KeyMax) err_n = E_INVALID;
                else begin
                  for (int i = 0; i < 5; i++)
                    if (tlen >= key_len(3'(i)) || key_char(3'(i), tlen[5:0]) != b)
                      cand_n[i] = 1'b0;
                  tlen_n = tlen + 1'b1;
                end
              end
              PH_AFTER_KEY: if (!is_ws(b)) begin
                if (b != ":") err_n = E_MALFORMED;
                else if (cur >= F_NONE) err_n = E_UNKNOWN;
                else ph_n = PH_AFTER_COLON;
              end
              PH_AFTER_COLON: if (!is_ws(b)) begin
                if (cur == F_CRASH || cur == F_SYM) begin
                  if (b != "\"") err_n = E_TYPE;
                  else begin tlen_n = '0; idm_n = 1'b1; ph_n = PH_STRING; end
                end else if (cur == F_DUP || cur == F_DUR) begin
                  if (b == "t") begin lword_n = 1'b0; lprog_n = 3'd1; ph_n = PH_LITERAL; end
                  else if (b == "f") begin lword_n = 1'b1; lprog_n = 3'd1; ph_n = PH_LITERAL; end
                  else err_n = E_TYPE;
                end else begin
                  if (b < "0" || b > "9") err_n = E_TYPE;
                  else begin num_n = 63'(d); ph_n = PH_NUMBER; end
                end
              end
              PH_STRING: begin
                if (b == "\"") begin
                  if (cur == F_CRASH) begin
                    if (!idm || exp_over || 32'(exp_len) != 32'(tlen)) err_n = E_MISMATCH;
                    else fin = 1'b1;
                  end else if (tlen == 7'd0) err_n = E_INVALID;
                  else fin = 1'b1;
                end else if (b == "\\" || b < 8'h20 || tlen >= ValueMax) err_n = E_INVALID;
                else begin
                  if (cur == F_CRASH && (32'(tlen) >= 32'(exp_len) ||
                      32'(tlen) >= ID_BYTES || rd_data != b)) idm_n = 1'b0;
                  tlen_n = tlen + 1'b1;
                end
              end
              PH_LITERAL: begin
                if (lprog >= (lword ? 3'd5 : 3'd4) || lit_char(lword, lprog) != b)
                  err_n = E_TYPE;
                else begin
                  lprog_n = lprog + 1'b1;
                  if (lprog_n == (lword ? 3'd5 : 3'd4)) begin
                    if (cur == F_DUP) dupf_n = !lword; else durf_n = !lword;
                    fin = 1'b1;
                  end
                end
              end
              PH_NUMBER: begin
                if (b >= "0" && b <= "9") begin
                  prod = 66'(num) * 66'd10 + 66'(d);
                  if (num > MulLim || prod > 66'(Max63)) err_n = E_INVALID;
                  else num_n = prod[62:0];
                end else begin
                  if (seen[cur]) err_n = E_DUP;
                  else begin
                    seen_n = seen | bit1;
                    ph_n = PH_AFTER_VALUE;
                    if (!is_ws(b)) begin
                      if (b == "}") ph_n = PH_DONE;
                      else if (b == ",") ph_n = PH_OPEN;
                      else err_n = E_MALFORMED;
                    end
                  end
                end
              end
              PH_AFTER_VALUE: if (!is_ws(b)) begin
                if (b == "}") ph_n = PH_DONE;
                else if (b == ",") ph_n = PH_OPEN;
                else err_n = E_MALFORMED;
              end
              default: if (!is_ws(b)) err_n = E_TRAILING;
            endcase
            if (fin) begin
              if (seen[cur]) err_n = E_DUP;
              else begin seen_n = seen | bit1; ph_n = PH_AFTER_VALUE; end
            end
          end
        end
        default: begin
          res_v = 1'b1;
          if (exp_len == '0 && !exp_over) res_code = E_NULL;
          else if (err != E_NONE) res_code = err;
          else begin
            priority case (phase)
              PH_OPEN, PH_AFTER_COLON, PH_LITERAL: res_code = E_TYPE;
              PH_NUMBER: res_code = seen[cur] ? E_DUP : E_MALFORMED;
              PH_DONE: begin
                if (seen != 5'h1f) res_code = E_MISSING;
                else if (!durf) res_code = E_INVALID;
                else res_code = E_NONE;
              end
              default: res_code = E_MALFORMED;
            endcase
          end
          ph_n = PH_BEGIN; err_n = E_NONE; seen_n = '0; cur_n = '0; cand_n = 5'h1f;
          tlen_n = '0; idm_n = 1'b1; lprog_n = '0; lword_n = 1'b0; num_n = '0;
          dupf_n = 1'b0; durf_n = 1'b0; exp_len_n = '0; exp_over_n = 1'b0;
          exp_closed_n = 1'b0;
        end
      endcase
    end
  end

  // Advance the pipeline and commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0; out_valid <= 1'b0;
      phase <= PH_BEGIN; err <= E_NONE; seen <= '0; cur <= '0; cand <= 5'h1f;
      tlen <= '0; idm <= 1'b1; lprog <= '0; lword <= 1'b0; num <= '0;
      dupf <= 1'b0; durf <= 1'b0; exp_len <= '0; exp_over <= 1'b0; exp_closed <= 1'b0;
    end else begin
      s1_valid <= acc;
      phase <= ph_n; err <= err_n; seen <= seen_n; cur <= cur_n; cand <= cand_n;
      tlen <= tlen_n; idm <= idm_n; lprog <= lprog_n; lword <= lword_n; num <= num_n;
      dupf <= dupf_n; durf <= durf_n; exp_len <= exp_len_n; exp_over <= exp_over_n;
      exp_closed <= exp_closed_n;
      if (res_v) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_op <= op_t'(opcode);
      s1_byte <= data_byte;
    end
    if (res_v) begin
      error_code <= res_code;
      already_reported <= (res_code == E_NONE) && dupf;
      stored_durably <= (res_code == E_NONE) && durf;
      server_time_ms <= (res_code == E_NONE) ? num : '0;
    end
  end

  // A result only loads when the result register is free
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_v |-> !out_valid || out_ready)
    else $error("result overrun");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_op == OP_BYTE && err != E_NONE |=> err == $past(err))
    else $error("sticky error changed");
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code <= E_TRAILING)
    else $error("bad error code");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != E_NONE |-> server_time_ms == '0 && !already_reported)
    else $error("fields not zero on failure");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb import amv_pkg::*; ();

  typedef enum int {
    S_BEGIN, S_OPEN, S_KEY, S_AFTER_KEY, S_AFTER_COLON, S_STRING, S_LITERAL,
    S_NUMBER, S_AFTER_VALUE, S_DONE
  } scan_t;

  typedef struct {
    logic [3:0]  code;
    logic        dup;
    logic        dur;
    logic [62:0] ms;
  } verdict_t;

  localparam int IdCap = 64;
  localparam logic [63:0] Max63w = 64'h7fffffffffffffff;
  localparam logic [2:0] NoField = 3'd5;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = 2'd0;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  error_code;
  logic        already_reported;
  logic        stored_durably;
  logic [62:0] server_time_ms;

  ack_message_validator u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .error_code(error_code), .already_reported(already_reported),
    .stored_durably(stored_durably), .server_time_ms(server_time_ms)
  );

  always #4 clk = ~clk;

  // Shadow parser state
  logic [7:0]  id_mem [IdCap];
  int          id_len;
  bit          id_over;
  bit          id_closed;
  scan_t       scan;
  logic [3:0]  first_err;
  logic [7:0]  seen;
  logic [2:0]  field;
  logic [4:0]  cand;
  int          tlen;
  bit          id_ok;
  int          lit_pos;
  logic [1:0]  lit_cand;
  logic [63:0] num;
  bit          dup_val;
  bit          dur_val;

  verdict_t    verdicts_due[$];
  int          failures = 0;
  int          beats_sent = 0;
  int          verdicts_seen = 0;
  int          src_idle = 0;
  int          sink_stall = 0;
  string       key_names[5] = '{"", "duplicate", "durable", "", ""};
  string       words[2] = '{"true", "false"};
  logic [7:0]  id_q[$];
  logic [7:0]  msg_q[$];

  function automatic bit is_blank(logic [7:0] b);
    return b == 8'h20 || b == 8'h09 || b == 8'h0a || b == 8'h0d;
  endfunction

  task automatic clear_parser();
    foreach (id_mem[i]) id_mem[i] = 8'd0;
    id_len = 0; id_over = 0; id_closed = 0;
    scan = S_BEGIN; first_err = E_NONE; seen = 8'd0; field = 3'd0;
    cand = 5'h1f; tlen = 0; id_ok = 1; lit_pos = 0; lit_cand = 2'b11;
    num = 64'd0; dup_val = 0; dur_val = 0;
  endtask

  function automatic void note_err(logic [3:0] c);
    if (first_err == E_NONE) first_err = c;
  endfunction

  function automatic void close_value();
    logic [7:0] bit_m;
    bit_m = 8'd1 << field;
    if ((seen & bit_m) != 0) begin
      note_err(E_DUP);
    end else begin
      seen = seen | bit_m;
      scan = S_AFTER_VALUE;
    end
  endfunction

  task automatic after_val(logic [7:0] b);
    if (is_blank(b)) return;
    if (b == "}") scan = S_DONE;
    else if (b == ",") scan = S_OPEN;
    else note_err(E_MALFORMED);
  endtask

  // Advance the shadow parser by one message byte
  task automatic scan_byte(logic [7:0] b);
    int w;
    logic [63:0] d;
    if (first_err != E_NONE) return;
    case (scan)
      S_BEGIN: begin
        if (is_blank(b)) return;
        if (b == "{") scan = S_OPEN;
        else note_err(E_MALFORMED);
      end
      S_OPEN: begin
        if (is_blank(b)) return;
        if (b == "}") scan = S_DONE;
        else if (b == "\"") begin
          tlen = 0; cand = 5'h1f; scan = S_KEY;
        end else note_err(E_TYPE);
      end
      S_KEY: begin
        if (b == "\"") begin
          field = NoField;
          for (int k = 0; k < 5; k++)
            if (cand[k] && key_names[k].len() == tlen) field = k[2:0];
          scan = S_AFTER_KEY;
        end else if (b == "\\" || b < 8'h20 || tlen >= 39) begin
          note_err(E_INVALID);
        end else begin
          for (int k = 0; k < 5; k++)
            if (tlen >= key_names[k].len() || key_names[k][tlen] != b) cand[k] = 1'b0;
          tlen++;
        end
      end
      S_AFTER_KEY: begin
        if (is_blank(b)) return;
        if (b != ":") note_err(E_MALFORMED);
        else if (field >= NoField) note_err(E_UNKNOWN);
        else scan = S_AFTER_COLON;
      end
      S_AFTER_COLON: begin
        if (is_blank(b)) return;
        if (field == F_CRASH || field == F_SYM) begin
          if (b != "\"") begin note_err(E_TYPE); return; end
          tlen = 0; id_ok = 1; scan = S_STRING;
        end else if (field == F_DUP || field == F_DUR) begin
          if (b == "t") lit_cand = 2'b01;
          else if (b == "f") lit_cand = 2'b10;
          else begin note_err(E_TYPE); return; end
          lit_pos = 1; scan = S_LITERAL;
        end else begin
          if (b < "0" || b > "9") begin note_err(E_TYPE); return; end
          num = 64'(b - "0"); scan = S_NUMBER;
        end
      end
      S_STRING: begin
        if (b == "\"") begin
          if (field == F_CRASH) begin
            if (!id_ok || id_over || tlen != id_len) note_err(E_MISMATCH);
            else close_value();
          end else if (tlen == 0) note_err(E_INVALID);
          else close_value();
        end else if (b == "\\" || b < 8'h20 || tlen >= 64) begin
          note_err(E_INVALID);
        end else begin
          if (field == F_CRASH && (tlen >= id_len || tlen >= IdCap || id_mem[tlen] != b))
            id_ok = 0;
          tlen++;
        end
      end
      S_LITERAL: begin
        w = lit_cand[1] ? 1 : 0;
        if (lit_pos >= words[w].len() || words[w][lit_pos] != b) begin
          note_err(E_TYPE); return;
        end
        lit_pos++;
        if (lit_pos == words[w].len()) begin
          if (field == F_DUP) dup_val = (w == 0);
          else dur_val = (w == 0);
          close_value();
        end
      end
      S_NUMBER: begin
        if (b >= "0" && b <= "9") begin
          d = 64'(b - "0");
          if (num > (Max63w - d) / 64'd10) note_err(E_INVALID);
          else num = num * 64'd10 + d;
          return;
        end
        close_value();
        if (first_err == E_NONE) after_val(b);
      end
      S_AFTER_VALUE: after_val(b);
      default: if (!is_blank(b)) note_err(E_TRAILING);
    endcase
  endtask

  function automatic logic [3:0] closing_code();
    if (id_len == 0 && !id_over) return E_NULL;
    if (first_err != E_NONE) return first_err;
    case (scan)
      S_OPEN, S_AFTER_COLON, S_LITERAL: return E_TYPE;
      S_NUMBER: begin
        close_value();
        return first_err != E_NONE ? first_err : E_MALFORMED;
      end
      S_DONE: begin
        if (seen != 8'h1f) return E_MISSING;
        if (!dur_val) return E_INVALID;
        return E_NONE;
      end
      default: return E_MALFORMED;
    endcase
  endfunction

  // Update the shadow state for one accepted beat
  task automatic predict_beat(logic [1:0] op, logic [7:0] b);
    verdict_t v;
    case (op)
      OP_START: clear_parser();
      OP_EXPECT: begin
        if (!id_closed) begin
          if (b == 8'd0) id_closed = 1;
          else if (id_len < IdCap) begin id_mem[id_len] = b; id_len++; end
          else id_over = 1;
        end
      end
      OP_BYTE: scan_byte(b);
      default: begin
        v.code = closing_code();
        v.dup = (v.code == E_NONE) && dup_val;
        v.dur = (v.code == E_NONE) && dur_val;
        v.ms = (v.code == E_NONE) ? num[62:0] : 63'd0;
        verdicts_due.push_back(v);
        clear_parser();
      end
    endcase
  endtask

  // Send one beat, idling first at random
  task automatic send_beat(logic [1:0] op, logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    predict_beat(op, b);
  endtask

  task automatic send_text(string id, string msg);
    send_beat(OP_START, 8'($urandom));
    for (int i = 0; i < id.len(); i++) send_beat(OP_EXPECT, id[i]);
    for (int i = 0; i < msg.len(); i++) send_beat(OP_BYTE, msg[i]);
    send_beat(OP_END, 8'($urandom));
  endtask

  // Drive the sink stall
  always @(posedge clk) out_ready <= ($urandom_range(99) >= sink_stall);

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result beat code=%0d", error_code);
        failures++;
      end else begin
        v = verdicts_due.pop_front();
        if (error_code !== v.code) begin
          $error("error_code expected %0d actual %0d", v.code, error_code); failures++;
        end
        if (already_reported !== v.dup) begin
          $error("already_reported expected %0d actual %0d", v.dup, already_reported);
          failures++;
        end
        if (stored_durably !== v.dur) begin
          $error("stored_durably expected %0d actual %0d", v.dur, stored_durably);
          failures++;
        end
        if (server_time_ms !== v.ms) begin
          $error("server_time_ms expected %0d actual %0d", v.ms, server_time_ms);
          failures++;
        end
      end
    end
  end

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7e)); while (c == "\"" || c == "\\");
    return c;
  endfunction

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic push_blank();
    logic [7:0] ws[4] = '{8'h20, 8'h09, 8'h0a, 8'h0d};
    while ($urandom_range(9) == 0) msg_q.push_back(ws[$urandom_range(3)]);
  endtask

  task automatic push_value(int k);
    logic [63:0] v;
    int n;
    case (k)
      0: begin
        msg_q.push_back("\"");
        foreach (id_q[i]) msg_q.push_back(id_q[i]);
        if ($urandom_range(7) == 0) msg_q.push_back(text_char());
        msg_q.push_back("\"");
      end
      1, 2: push_str(((k == 2 && $urandom_range(9) != 0) || $urandom_range(1)) ?
                     words[0] : words[1]);
      3: begin
        case ($urandom_range(9))
          0: v = {1'b0, 31'($urandom), 32'($urandom)};
          1: v = Max63w - 64'($urandom_range(3));
          2: v = Max63w + 64'($urandom_range(1, 9));
          default: v = 64'($urandom_range(0, 99999));
        endcase
        if ($urandom_range(15) == 0) push_str("00");
        push_str($sformatf("%0d", v));
      end
      default: begin
        msg_q.push_back("\"");
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 6);
        repeat (n) msg_q.push_back(text_char());
        msg_q.push_back("\"");
      end
    endcase
  endtask

  // Build a mostly well-formed acknowledgement with random content
  task automatic build_message();
    int keys[$];
    int n, j, t, p;
    id_q.delete();
    msg_q.delete();
    case ($urandom_range(19))
      0: n = 0;
      1: n = $urandom_range(64, 70);
      2: n = $urandom_range(13, 64);
      default: n = $urandom_range(1, 10);
    endcase
    repeat (n) id_q.push_back(text_char());
    for (int k = 0; k < 5; k++) keys.push_back(k);
    if ($urandom_range(9) == 0) keys.delete($urandom_range(4));
    if ($urandom_range(9) == 0) keys.push_back($urandom_range(4));
    for (int i = keys.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = keys[i]; keys[i] = keys[j]; keys[j] = t;
    end
    push_blank();
    msg_q.push_back("{");
    foreach (keys[i]) begin
      push_blank();
      msg_q.push_back("\"");
      push_str(key_names[keys[i]]);
      if ($urandom_range(29) == 0) msg_q.push_back(text_char());
      msg_q.push_back("\"");
      push_blank();
      msg_q.push_back(":");
      push_blank();
      push_value(keys[i]);
      push_blank();
      if (i != keys.size() - 1 || $urandom_range(3) == 0) msg_q.push_back(",");
    end
    push_blank();
    msg_q.push_back("}");
    push_blank();
    // Break some messages
    if ($urandom_range(3) == 0) begin
      p = $urandom_range(msg_q.size() - 1);
      case ($urandom_range(4))
        0: msg_q[p] = 8'($urandom);
        1: msg_q.delete(p);
        2: while (msg_q.size() > p) void'(msg_q.pop_back());
        3: msg_q.insert(p, 8'($urandom));
        default: msg_q.push_back(text_char());
      endcase
    end
  endtask

  task automatic send_message();
    int late;
    bit term;
    late = ($urandom_range(9) == 0) ? $urandom_range(id_q.size()) : id_q.size();
    term = $urandom_range(1);
    if ($urandom_range(15) == 0) send_beat(2'($urandom), 8'($urandom));
    send_beat(OP_START, 8'($urandom));
    for (int i = 0; i < late; i++) send_beat(OP_EXPECT, id_q[i]);
    foreach (msg_q[i]) begin
      if (i == 3)
        for (int k = late; k < id_q.size(); k++) send_beat(OP_EXPECT, id_q[k]);
      send_beat(OP_BYTE, msg_q[i]);
    end
    if (msg_q.size() <= 3)
      for (int k = late; k < id_q.size(); k++) send_beat(OP_EXPECT, id_q[k]);
    if (term) begin
      send_beat(OP_EXPECT, 8'd0);
      repeat ($urandom_range(2)) send_beat(OP_EXPECT, 8'($urandom));
    end
    send_beat(OP_END, 8'($urandom));
  endtask

  task automatic test_directed();
    string good;
    src_idle = 0;
    sink_stall = 0;
    good = {"{\"", key_names[0], "\":\"ab\",\"duplicate\":true,\"durable\":true,"};
    send_text("", "{}");
    send_text("ab", {good, "\"", key_names[3], "\":9223372036854775807,",
                     "\"", key_names[4], "\":\"x\",}"});
    send_text("ab", {good, "\"", key_names[3], "\":9223372036854775808}"});
    send_text("ab", "{} x");
    send_text("ab", {"{\"durable\":false,\"", key_names[0], "\":\"ab\""});
    send_text("ab", {"{\"", key_names[0], "\":\"a\\b\"}"});
    send_text("ab", {"{\"", key_names[3], "\":5"});
    send_text("ab", "{\"zz\":1}");
    send_beat(OP_END, 8'hff);
  endtask

  task automatic test_random(int idle, int stall, int beats, int results);
    int b0, r0;
    src_idle = idle;
    sink_stall = stall;
    b0 = beats_sent;
    r0 = verdicts_due.size() + verdicts_seen;
    while (beats_sent - b0 < beats || verdicts_due.size() + verdicts_seen - r0 < results) begin
      build_message();
      send_message();
    end
  endtask

  initial begin
    key_names[0] = $sformatf("%s", KeyIdText);
    key_names[3] = $sformatf("%s", KeyTimeText);
    key_names[4] = $sformatf("%s", KeyStatusText);
    clear_parser();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 0, 400, 3);
    test_random(49, 0, 400, 3);
    test_random(0, 49, 400, 3);
    test_random(21, 21, 400, 3);
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Give up after a generous time
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== ack_message_validator.f =====
rtl/amv_pkg.sv
rtl/ack_message_validator.sv
test/tb.sv
